FILE: rtl/core/q2e_pkg.sv
// q2e_pkg: constants, types and the cordic angle table for quaternion_to_euler
// no dependencies
package q2e_pkg;

  localparam int QW   = 16;
  localparam int VW   = 36;
  localparam int AW   = 26;
  localparam int MAXSTEPS = 24;
  localparam logic signed [35:0] Q28_ONE     = 36'sd268435456;
  localparam logic signed [35:0] PITCH_LIMIT = 36'sd134217593;
  localparam logic signed [AW-1:0] ANG_90    = 26'sd5898240;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [AW-1:0] ang_t;

  function automatic ang_t atan_tab(input int i);
    ang_t t;
    unique case (i)
      0: t = 26'sd2949120;   1: t = 26'sd1740967;   2: t = 26'sd919879;
      3: t = 26'sd466945;    4: t = 26'sd234379;    5: t = 26'sd117304;
      6: t = 26'sd58666;     7: t = 26'sd29335;     8: t = 26'sd14668;
      9: t = 26'sd7334;     10: t = 26'sd3667;     11: t = 26'sd1833;
      12: t = 26'sd917;     13: t = 26'sd458;      14: t = 26'sd229;
      15: t = 26'sd115;     16: t = 26'sd57;       17: t = 26'sd29;
      18: t = 26'sd14;      19: t = 26'sd7;        20: t = 26'sd4;
      21: t = 26'sd2;       22: t = 26'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/q2e_cordic.sv
// q2e_cordic: pipelined vectoring cordic, one register stage per step
// depends on q2e_pkg; payload rides alongside as a side word
module q2e_cordic #(
  parameter int STEPS = 16,
  parameter int SW    = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  q2e_pkg::vec_t    x_i,
  input  q2e_pkg::vec_t    y_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output q2e_pkg::ang_t    ang_o,
  output logic [SW-1:0]    side_o
);
  import q2e_pkg::*;

  localparam int N = (STEPS > MAXSTEPS) ? MAXSTEPS : STEPS;

  vec_t          x_q [N+1];
  vec_t          y_q [N+1];
  ang_t          a_q [N+1];
  logic [SW-1:0] s_q [N+1];
  logic [N:0]    v_q;
  logic [N:0]    z_q;
  vec_t          x0_d, y0_d;
  ang_t          a0_d;
  logic          zero_d;

  // prerotation into the right half plane
  always_comb begin
    x0_d = x_i;
    y0_d = y_i;
    a0_d = '0;
    zero_d = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d = y_i;
        y0_d = -x_i;
        a0_d = ANG_90;
      end else begin
        x0_d = -y_i;
        y0_d = x_i;
        a0_d = -ANG_90;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= x0_d;
    y_q[0] <= y0_d;
    a_q[0] <= a0_d;
    s_q[0] <= side_i;
    z_q[0] <= zero_d;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      s_q[i+1] <= s_q[i];
      z_q[i+1] <= z_q[i];
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        a_q[i+1] <= a_q[i] + atan_tab(i);
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        a_q[i+1] <= a_q[i] - atan_tab(i);
      end
    end
  end

  // zero vector gives angle zero
  assign valid_o = v_q[N];
  assign ang_o   = z_q[N] ? '0 : a_q[N];
  assign side_o  = s_q[N];

endmodule

FILE: rtl/core/quaternion_to_euler_top.sv
// quaternion to euler angles, fully pipelined: one quaternion per clock, no stall.
// in order: products, sums, radicand, square root (29 result bits, one bit a stage),
// cordic (prerotation, one step a stage), rounding; the pitch square root sets the depth,
// roll and yaw are delayed to match. busy is always low; each result word appears
// for one cycle with done_o high and cannot be held off.
// depends on q2e_pkg and q2e_cordic
module quaternion_to_euler_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               done_o,
  output logic signed [13:0] pitch_deg_o,
  output logic signed [14:0] yaw_deg_o,
  output logic signed [14:0] roll_deg_o,
  output logic               pitch_clamped_o
);
  import q2e_pkg::*;

  localparam int RB = 29;

  assign busy = 1'b0;

  // stage 1: products
  logic              v1_q;
  logic signed [31:0] wz_q, xy_q, zz_q, xx_q, wy_q, xz_q, yy_q, wx_q, yz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    wz_q <= quat_w_i * quat_z_i;
    xy_q <= quat_x_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    xx_q <= quat_x_i * quat_x_i;
    wy_q <= quat_w_i * quat_y_i;
    xz_q <= quat_x_i * quat_z_i;
    yy_q <= quat_y_i * quat_y_i;
    wx_q <= quat_w_i * quat_x_i;
    yz_q <= quat_y_i * quat_z_i;
  end

  // stage 2: sums and clamp test
  logic v2_q, clamp2_q;
  vec_t rs_q, rc_q, ys_q, yc_q, s2_q;
  logic [27:0] mag2_q;
  vec_t pt_d;
  always_comb pt_d = VW'(wx_q) - VW'(yz_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    rs_q <= (VW'(wz_q) + VW'(xy_q)) <<< 1;
    rc_q <= Q28_ONE - ((VW'(zz_q) + VW'(xx_q)) <<< 1);
    ys_q <= (VW'(wy_q) + VW'(xz_q)) <<< 1;
    yc_q <= Q28_ONE - ((VW'(xx_q) + VW'(yy_q)) <<< 1);
    s2_q <= pt_d <<< 1;
    clamp2_q <= (pt_d > PITCH_LIMIT) || (pt_d < -PITCH_LIMIT);
    mag2_q <= pt_d < 0 ? 28'(-(pt_d <<< 1)) : 28'(pt_d <<< 1);
  end

  // stage 3: radicand 2^56 - s*s
  logic v3_q, clamp3_q;
  vec_t rs3_q, rc3_q, ys3_q, yc3_q, s3_q;
  logic [56:0] rad_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    rs3_q <= rs_q; rc3_q <= rc_q; ys3_q <= ys_q; yc3_q <= yc_q; s3_q <= s2_q;
    clamp3_q <= clamp2_q;
    rad_q <= (57'd1 << 56) - ({29'd0, mag2_q} * {29'd0, mag2_q});
  end

  // square root, one result bit a stage
  logic        sv_q   [RB+1];
  logic [57:0] rem_q  [RB+1];
  logic [28:0] root_q [RB+1];
  logic [57:0] rr_q   [RB+1];
  vec_t        srs_q [RB+1], src_q [RB+1], sys_q [RB+1], syc_q [RB+1], ss_q [RB+1];
  logic        scl_q [RB+1];
  always_comb begin
    sv_q[0] = v3_q; rem_q[0] = '0; root_q[0] = '0; rr_q[0] = {1'b0, rad_q};
    srs_q[0] = rs3_q; src_q[0] = rc3_q; sys_q[0] = ys3_q; syc_q[0] = yc3_q;
    ss_q[0] = s3_q; scl_q[0] = clamp3_q;
  end
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    logic [57:0] r_d, t_d;
    always_comb begin
      r_d = {rem_q[k][55:0], rr_q[k][57-2*k -: 2]} ;
      t_d = {27'd0, root_q[k], 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else sv_q[k+1] <= sv_q[k];
    end
    always_ff @(posedge clk_i) begin
      rr_q[k+1] <= rr_q[k];
      srs_q[k+1] <= srs_q[k]; src_q[k+1] <= src_q[k];
      sys_q[k+1] <= sys_q[k]; syc_q[k+1] <= syc_q[k];
      ss_q[k+1] <= ss_q[k]; scl_q[k+1] <= scl_q[k];
      if (r_d >= t_d) begin
        rem_q[k+1]  <= r_d - t_d;
        root_q[k+1] <= {root_q[k][27:0], 1'b1};
      end else begin
        rem_q[k+1]  <= r_d;
        root_q[k+1] <= {root_q[k][27:0], 1'b0};
      end
    end
  end

  // the radicand is padded to 58 bits with a leading zero, taken a pair a stage

  ang_t ra, ya, pa;
  logic rv, yv, pv, clamp_c;
  logic unused_a, pneg_c;
  vec_t pc_d;
  assign pc_d = VW'(root_q[RB]);

  q2e_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_roll (
    .clk_i, .rst_ni, .valid_i(sv_q[RB]), .x_i(src_q[RB]), .y_i(srs_q[RB]),
    .side_i(scl_q[RB]), .valid_o(rv), .ang_o(ra), .side_o(clamp_c));
  q2e_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_yaw (
    .clk_i, .rst_ni, .valid_i(sv_q[RB]), .x_i(syc_q[RB]), .y_i(sys_q[RB]),
    .side_i(1'b0), .valid_o(yv), .ang_o(ya), .side_o(unused_a));
  q2e_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_pitch (
    .clk_i, .rst_ni, .valid_i(sv_q[RB]), .x_i(pc_d), .y_i(ss_q[RB]),
    .side_i(ss_q[RB][VW-1]), .valid_o(pv), .ang_o(pa), .side_o(pneg_c));

  // output rounding, saturation and clamp
  function automatic logic signed [15:0] to_out(input ang_t a, input logic signed [15:0] lim);
    logic signed [26:0] s;
    logic signed [16:0] q;
    s = {a[AW-1], a} + 27'sd512;
    q = 17'(s >>> 10);
    if (q > 17'(lim)) q = 17'(lim);
    if (q < -17'(lim)) q = -17'(lim);
    return 16'(q);
  endfunction

  // sign of the clamped pitch equals the sign of s, which the pitch cordic carries
  logic signed [15:0] ro_d, yo_d, po_d;
  always_comb begin
    ro_d = to_out((ra == ANG_90 + ANG_90 + ANG_90 + ANG_90) ? ra : ra, 16'sd11520);
    yo_d = to_out(ya, 16'sd11520);
    if (clamp_c) po_d = pneg_c ? -16'sd5760 : 16'sd5760;
    else po_d = to_out(pa, 16'sd5760);
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= rv & yv & pv;
  end
  always_ff @(posedge clk_i) begin
    roll_deg_o      <= 15'(ro_d);
    yaw_deg_o       <= 15'(yo_d);
    pitch_deg_o     <= 14'(po_d);
    pitch_clamped_o <= clamp_c;
  end
  assign done_o = done_q;

  logic unused_ok;
  assign unused_ok = unused_a;

endmodule

FILE: rtl/core/q2e_checker.sv
// q2e_checker: port level checks on quaternion_to_euler_top
// depends on nothing; bound to the top level below
module q2e_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy,
  input logic               done_o,
  input logic signed [13:0] pitch_deg_o,
  input logic signed [14:0] yaw_deg_o,
  input logic signed [14:0] roll_deg_o,
  input logic               pitch_clamped_o
);
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && pitch_clamped_o |-> pitch_deg_o == 14'sd5760 || pitch_deg_o == -14'sd5760)
    else $error("clamped pitch not at limit");
  a_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pitch_deg_o <= 14'sd5760 && pitch_deg_o >= -14'sd5760)
    else $error("pitch out of range");
  a_ang: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> yaw_deg_o <= 15'sd11520 && yaw_deg_o >= -15'sd11520
           && roll_deg_o <= 15'sd11520 && roll_deg_o >= -15'sd11520)
    else $error("angle out of range");
endmodule

bind quaternion_to_euler_top q2e_checker u_q2e_checker (.*);

FILE: tb/quaternion_to_euler_top_tb.sv
// testbench for quaternion_to_euler_top: directed and random quaternions checked
// against a behavioural model of the fixed-point cordic conversion
// depends on q2e_pkg and quaternion_to_euler_top
`timescale 1ns / 1ps

module quaternion_to_euler_top_tb;
  import q2e_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = 3 + 29 + STEPS + 1 + 1;

  typedef struct packed {
    logic signed [13:0] pitch;
    logic signed [14:0] yaw;
    logic signed [14:0] roll;
    logic               clamped;
  } angles_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [15:0] quat_x_i, quat_y_i, quat_z_i, quat_w_i;
  logic               done_o;
  logic signed [13:0] pitch_deg_o;
  logic signed [14:0] yaw_deg_o, roll_deg_o;
  logic               pitch_clamped_o;

  angles_t angles_q[$];
  int      n_errors;
  int      n_words;
  int      n_clamped;

  quaternion_to_euler_top #(.CORDIC_STEPS(STEPS)) dut (
    .clk_i, .rst_ni, .start, .busy, .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .done_o, .pitch_deg_o, .yaw_deg_o, .roll_deg_o, .pitch_clamped_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint floor_shr(longint v, int k);
    if (v >= 0) return v >>> k;
    return -(((-v) - 1) >>> k) - 1;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint acc, t, nx, ny;
    int n;
    acc = 0;
    n = (STEPS > MAXSTEPS) ? MAXSTEPS : STEPS;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = longint'(ANG_90);
      end else begin
        x = -y; y = t; acc = -longint'(ANG_90);
      end
    end
    for (int i = 0; i < n; i++) begin
      if (y >= 0) begin
        nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); acc += longint'(atan_tab(i));
      end else begin
        nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); acc -= longint'(atan_tab(i));
      end
      x = nx; y = ny;
    end
    return acc;
  endfunction

  function automatic longint to_degrees(longint a, longint lim);
    longint q;
    q = floor_shr(a + 512, 10);
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic angles_t euler_angles(logic signed [15:0] qx, logic signed [15:0] qy,
                                           logic signed [15:0] qz, logic signed [15:0] qw);
    longint x, y, z, w, pt, s, one, lim;
    longint unsigned mag;
    angles_t r;
    x = qx; y = qy; z = qz; w = qw;
    one = longint'(Q28_ONE);
    lim = longint'(PITCH_LIMIT);
    r.roll = 15'(to_degrees(vector_angle(2 * (w * z + x * y), one - 2 * (z * z + x * x)), 11520));
    r.yaw  = 15'(to_degrees(vector_angle(2 * (w * y + x * z), one - 2 * (x * x + y * y)), 11520));
    pt = w * x - y * z;
    r.clamped = 1'b1;
    if (pt > lim) begin
      r.pitch = 14'sd5760;
    end else if (pt < -lim) begin
      r.pitch = -14'sd5760;
    end else begin
      r.clamped = 1'b0;
      s = 2 * pt;
      mag = longint'(s < 0 ? -s : s);
      r.pitch = 14'(to_degrees(vector_angle(s, int_sqrt((64'd1 << 56) - mag * mag)), 5760));
    end
    return r;
  endfunction

  task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    quat_x_i <= qx; quat_y_i <= qy; quat_z_i <= qz; quat_w_i <= qw;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    angles_q.push_back(euler_angles(qx, qy, qz, qw));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    angles_t exp_a;
    if (rst_ni && done_o) begin
      n_words++;
      if (angles_q.size() == 0) begin
        $display("%0t: unexpected word pitch %0d yaw %0d roll %0d", $time,
                 pitch_deg_o, yaw_deg_o, roll_deg_o);
        n_errors++;
      end else begin
        exp_a = angles_q.pop_front();
        if (exp_a.clamped) n_clamped++;
        if (pitch_deg_o !== exp_a.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, exp_a.pitch, pitch_deg_o);
          n_errors++;
        end
        if (yaw_deg_o !== exp_a.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, exp_a.yaw, yaw_deg_o);
          n_errors++;
        end
        if (roll_deg_o !== exp_a.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, exp_a.roll, roll_deg_o);
          n_errors++;
        end
        if (pitch_clamped_o !== exp_a.clamped) begin
          $display("%0t: clamp expected %0b actual %0b", $time, exp_a.clamped,
                   pitch_clamped_o);
          n_errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(11585, 0, 0, 11585);
    send_quat(-11585, 0, 0, 11585);
    send_quat(11586, 0, 0, 11586);
    send_quat(11585, 0, 0, 11586);
    send_quat(0, 11585, 11585, 0);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(0, 0, 16384, -16384);
    send_quat(0, 0, -1, 0);
    send_quat(0, -16384, 0, -1);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(-8192, 8192, -8192, 8192);
    send_quat(8192, 8192, 8192, -8192);
    send_quat(1, -1, 1, -1);
  endtask

  task automatic test_unit_random();
    real a, b, c, d, nrm;
    for (int i = 0; i < 450; i++) begin
      a = $urandom_range(0, 65535) - 32768.0;
      b = $urandom_range(0, 65535) - 32768.0;
      c = $urandom_range(0, 65535) - 32768.0;
      d = $urandom_range(0, 65535) - 32768.0;
      nrm = $sqrt(a * a + b * b + c * c + d * d);
      if (nrm < 1.0) nrm = 1.0;
      send_quat(16'($rtoi(a * 16384.0 / nrm)), 16'($rtoi(b * 16384.0 / nrm)),
                16'($rtoi(c * 16384.0 / nrm)), 16'($rtoi(d * 16384.0 / nrm)));
    end
  endtask

  task automatic test_near_gimbal();
    int e;
    for (int i = 0; i < 100; i++) begin
      e = $urandom_range(0, 6) - 3;
      send_quat(16'(11585 + e), 16'($urandom_range(0, 7) - 3), 16'($urandom_range(0, 7) - 3),
                ($urandom_range(0, 1) ? 16'sd11585 : -16'sd11585) + 16'(e));
    end
  endtask

  task automatic test_raw_random();
    for (int i = 0; i < 200; i++)
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int waited;
    n_errors = 0; n_words = 0; n_clamped = 0;
    start = 1'b0;
    quat_x_i = '0; quat_y_i = '0; quat_z_i = '0; quat_w_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_unit_random();
    test_near_gimbal();
    test_raw_random();
    start <= 1'b0;
    waited = 0;
    while (angles_q.size() != 0 && waited < 20 * LATENCY) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY) @(posedge clk_i);
    if (angles_q.size() != 0) begin
      $display("%0t: %0d words never arrived", $time, angles_q.size());
      n_errors++;
    end
    $display("checked %0d angle words (%0d at the gimbal clamp), %0d errors",
             n_words, n_clamped, n_errors);
    if (n_errors == 0)
      $display("PASS quaternion_to_euler_top");
    else
      $display("FAIL quaternion_to_euler_top");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL quaternion_to_euler_top");
    $finish;
  end

endmodule
